FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define BVM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication form: antecedent holds -> consequent on the next edge.
`define BVM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bvm_pkg.sv
// Package: opcodes, field positions and widths of the bytecode VM.
`default_nettype none

package bvm_pkg;

  localparam int unsigned WORD_W         = 32;
  localparam int unsigned PC_W           = 13;
  localparam int unsigned IMM_W          = 20;
  localparam int unsigned TGT_W          = 12;
  localparam int unsigned FIELD_W        = 8;
  localparam int unsigned OP_W           = 4;
  localparam int unsigned DATA_WORDS_DEF = 256;
  localparam int unsigned FIELD_VALUES   = 1 << FIELD_W;

  localparam logic [PC_W-1:0] PROG_LEN_RST = 13'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 4'd0,
    OP_ADD  = 4'd1,
    OP_BNE  = 4'd2,
    OP_EMIT = 4'd3,
    OP_RET  = 4'd4
  } op_e;

endpackage

`default_nettype wire

FILE: sv/bvm_dmem.sv
// Data memory: one write port, two registered read ports, per-entry valid bits.
`default_nettype none

module bvm_dmem #(
  parameter int unsigned DATA_WORDS = bvm_pkg::DATA_WORDS_DEF,
  localparam int unsigned AW = $clog2(DATA_WORDS)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [bvm_pkg::WORD_W-1:0] wdata_i,
  input  wire logic                       re_i,
  input  wire logic [AW-1:0]              raddr_x_i,
  input  wire logic [AW-1:0]              raddr_y_i,
  output logic      [bvm_pkg::WORD_W-1:0] rdata_x_o,
  output logic      [bvm_pkg::WORD_W-1:0] rdata_y_o
);
  import bvm_pkg::*;

  logic [WORD_W-1:0]     mem_q [DATA_WORDS];
  logic [DATA_WORDS-1:0] vld_q;
  logic [WORD_W-1:0]     rd_x_q;
  logic [WORD_W-1:0]     rd_y_q;
  logic                  rd_x_vld_q;
  logic                  rd_y_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_x_q <= mem_q[raddr_x_i];
      rd_y_q <= mem_q[raddr_y_i];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_x_vld_q <= 1'b0;
      rd_y_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_x_vld_q <= vld_q[raddr_x_i];
        rd_y_vld_q <= vld_q[raddr_y_i];
      end
    end
  end

  assign rdata_x_o = rd_x_vld_q ? rd_x_q : '0;
  assign rdata_y_o = rd_y_vld_q ? rd_y_q : '0;

endmodule

`default_nettype wire

FILE: sv/bytecode_register_vm_execute.sv
// Top level: bytecode VM execute stage with data memory and program counter.
// Takes one packed instruction per beat and returns one result beat per
// instruction, one instruction per cycle sustained while out_ready_i is high.
// An accepted word reads its operands from the dual-read-port data memory at
// the accepting edge; the execute stage then executes, writes the memory and
// updates the pc once the output register is free, and registers the result.
// A write followed directly by a read of the same word is forwarded, so
// back-to-back dependent instructions run at full rate. The memory is zero
// after reset with no clearing pass. Once pc reaches program_length, further
// words are ignored and report the held pc with done set. The user must write
// program_length through cfg_we_i/cfg_wdata_i only while the block is idle;
// the block does not enforce this. It applies to the next instruction.
`default_nettype none

module bytecode_register_vm_execute #(
  parameter int unsigned DATA_WORDS = bvm_pkg::DATA_WORDS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic        [bvm_pkg::PC_W-1:0]   cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic        [bvm_pkg::WORD_W-1:0] instruction_word_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic             [bvm_pkg::PC_W-1:0]   next_pc_o,
  output logic                                   print_valid_o,
  output logic signed      [bvm_pkg::WORD_W-1:0] print_value_o,
  output logic                                   done_res_o,
  output logic                                   illegal_o
);
  import bvm_pkg::*;

  localparam int unsigned AW = $clog2(DATA_WORDS);

  // Operand fields are taken modulo DATA_WORDS through an elaborated table.
  logic [AW-1:0] mod_tab [FIELD_VALUES];
  for (genvar g = 0; g < FIELD_VALUES; g++) begin : g_mod
    assign mod_tab[g] = AW'(g % DATA_WORDS);
  end

  // Decode at the input.
  logic [OP_W-1:0] in_op;
  logic [AW-1:0]   in_a;
  logic [AW-1:0]   in_b;
  logic [AW-1:0]   in_c;
  logic [AW-1:0]   in_x;
  logic            in_fire;

  assign in_op   = instruction_word_i[OP_W-1:0];
  assign in_a    = mod_tab[instruction_word_i[31:24]];
  assign in_b    = mod_tab[instruction_word_i[23:16]];
  assign in_c    = mod_tab[instruction_word_i[11:4]];
  assign in_x    = (in_op == OP_ADD) ? in_c : in_a;
  assign in_fire = in_valid_i && in_ready_o;

  // Execute stage registers.
  logic              s1_valid_q;
  logic [OP_W-1:0]   s1_op_q;
  logic [AW-1:0]     s1_a_q;
  logic [AW-1:0]     s1_x_q;
  logic [AW-1:0]     s1_y_q;
  logic [IMM_W-1:0]  s1_imm_q;
  logic [TGT_W-1:0]  s1_tgt_q;
  logic              s1_go;

  logic [PC_W-1:0]   pc_q;
  logic [PC_W-1:0]   prog_len_q;

  // Last write, for read-during-write forwarding.
  logic              fwd_vld_q;
  logic [AW-1:0]     fwd_addr_q;
  logic [WORD_W-1:0] fwd_data_q;

  logic              out_valid_q;
  logic [PC_W-1:0]   next_pc_q;
  logic              print_valid_q;
  logic [WORD_W-1:0] print_value_q;
  logic              done_q;
  logic              illegal_q;

  logic [WORD_W-1:0] mem_x;
  logic [WORD_W-1:0] mem_y;
  logic [WORD_W-1:0] opnd_x;
  logic [WORD_W-1:0] opnd_y;

  logic              wr_en;
  logic [WORD_W-1:0] wr_data;
  logic [PC_W-1:0]   nxt_pc;
  logic              pv;
  logic [WORD_W-1:0] pval;
  logic              bad;
  logic              halted;

  assign s1_go      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  bvm_dmem #(
    .DATA_WORDS (DATA_WORDS)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (wr_en && s1_go),
    .waddr_i   (s1_a_q),
    .wdata_i   (wr_data),
    .re_i      (in_fire),
    .raddr_x_i (in_x),
    .raddr_y_i (in_b),
    .rdata_x_o (mem_x),
    .rdata_y_o (mem_y)
  );

  assign opnd_x = (fwd_vld_q && fwd_addr_q == s1_x_q) ? fwd_data_q : mem_x;
  assign opnd_y = (fwd_vld_q && fwd_addr_q == s1_y_q) ? fwd_data_q : mem_y;
  assign halted = pc_q >= prog_len_q;

  always_comb begin
    nxt_pc  = pc_q + PC_W'(1);
    pv      = 1'b0;
    pval    = '0;
    bad     = 1'b0;
    wr_en   = 1'b0;
    wr_data = opnd_x + opnd_y;
    if (halted) begin
      nxt_pc = pc_q;
    end else begin
      case (op_e'(s1_op_q))
        OP_LOAD: begin
          wr_en   = 1'b1;
          wr_data = WORD_W'(s1_imm_q);
        end
        OP_ADD: begin
          wr_en = 1'b1;
        end
        OP_BNE: begin
          if (opnd_x != opnd_y) begin
            nxt_pc = PC_W'(s1_tgt_q);
          end
        end
        OP_EMIT: begin
          pv   = 1'b1;
          pval = opnd_x;
        end
        OP_RET: begin
        end
        default: begin
          bad = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q  <= in_op;
      s1_a_q   <= in_a;
      s1_x_q   <= in_x;
      s1_y_q   <= in_b;
      s1_imm_q <= instruction_word_i[23:4];
      s1_tgt_q <= instruction_word_i[15:4];
    end
    if (s1_go && wr_en) begin
      fwd_addr_q <= s1_a_q;
      fwd_data_q <= wr_data;
    end
    if (s1_go) begin
      next_pc_q     <= nxt_pc;
      print_valid_q <= pv;
      print_value_q <= pval;
      done_q        <= nxt_pc >= prog_len_q;
      illegal_q     <= bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_vld_q   <= 1'b0;
      pc_q        <= '0;
      prog_len_q  <= PROG_LEN_RST;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
        pc_q        <= nxt_pc;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_go && wr_en) begin
        fwd_vld_q <= 1'b1;
      end
      if (cfg_we_i) begin
        prog_len_q <= cfg_wdata_i;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = next_pc_q;
  assign print_valid_o = print_valid_q;
  assign print_value_o = print_value_q;
  assign done_res_o    = done_q;
  assign illegal_o     = illegal_q;

endmodule

`default_nettype wire

FILE: sv/bvm_checker.sv
// Port-level checker for the bytecode VM execute block, with its bind.
`default_nettype none
`include "assert_macros.svh"

module bvm_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic        [bvm_pkg::PC_W-1:0]   next_pc_o,
  input wire logic                              print_valid_o,
  input wire logic signed [bvm_pkg::WORD_W-1:0] print_value_o,
  input wire logic                              illegal_o
);

  // A stalled result beat stays up.
  `BVM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o, "result beat dropped while stalled")

  // A stalled result beat keeps its pc.
  `BVM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   $stable(next_pc_o), "result pc changed while stalled")

  // Print and illegal never come together.
  `BVM_ASSERT(a_print_legal, clk_i, rst_ni,
              out_valid_o |-> !(print_valid_o && illegal_o), "print with illegal opcode")

  // Non-print beats carry a zero value.
  `BVM_ASSERT(a_print_zero, clk_i, rst_ni,
              (out_valid_o && !print_valid_o) |-> (print_value_o == 0), "value without print")

endmodule

bind bytecode_register_vm_execute bvm_checker u_bvm_checker (.*);

`default_nettype wire
